// ===== rtl/core/k_way_sorted_merge_macros.svh =====
// assertion macros for the k-way merge block
// used by kwm_dpath, the only module under rtl/core that checks its own logic
`ifndef K_WAY_SORTED_MERGE_MACROS_SVH
`define K_WAY_SORTED_MERGE_MACROS_SVH

// same-cycle implication
`define KWM_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("kwm assertion failed");

// next-cycle implication
`define KWM_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("kwm assertion failed");

`endif

// ===== rtl/core/kwm_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and controller/datapath command and status types
// for the k-way merge block; no dependencies
package kwm_pkg;

  localparam int DEF_MAX_LISTS  = 8;
  localparam int DEF_VALUE_BITS = 32;

  localparam int IDX_W  = 3;
  localparam int ELEM_W = 32;
  localparam int CFG_W  = 4;

  typedef struct packed {
    logic take;
    logic scan_clr;
    logic scan_step;
    logic emit_none;
    logic emit_pop;
    logic restart;
  } kwm_cmd_t;

  typedef struct packed {
    logic waiting;
    logic heap_empty;
    logic merge_started;
    logic scan_last;
    logic best_fin;
    logic others_left;
    logic out_free;
  } kwm_stat_t;

endpackage

// ===== rtl/core/kwm_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for list elements and merged results
// depends on kwm_pkg for the field widths
interface kwm_in_if;
  import kwm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         list_index;
  logic signed [ELEM_W-1:0] elem_value;
  logic                     last_in_list;
  logic                     list_empty;

  modport source (
    output valid, list_index, elem_value, last_in_list, list_empty,
    input  ready
  );
  modport sink (
    input  valid, list_index, elem_value, last_in_list, list_empty,
    output ready
  );
endinterface

interface kwm_out_if;
  import kwm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] out_value;
  logic [IDX_W-1:0]         source_list;
  logic                     refill_needed;
  logic                     merge_last;
  logic                     no_elements;

  modport source (
    output valid, out_value, source_list, refill_needed, merge_last, no_elements,
    input  ready
  );
  modport sink (
    input  valid, out_value, source_list, refill_needed, merge_last, no_elements,
    output ready
  );
endinterface

// ===== rtl/core/kwm_ctrl.sv =====
`timescale 1ns / 1ps
// merge sequencer: takes a request, checks for waiting lists, runs the
// minimum scan and pops; depends on kwm_pkg command/status types
module kwm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kwm_pkg::kwm_stat_t stat,
  output kwm_pkg::kwm_cmd_t  cmd
);
  import kwm_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.waiting) begin
          state_nxt = S_IDLE;
        end else if (stat.heap_empty) begin
          // merge over: report all-empty once, or just start over
          if (stat.merge_started) begin
            cmd.restart = 1'b1;
            state_nxt   = S_IDLE;
          end else if (stat.out_free) begin
            cmd.emit_none = 1'b1;
            cmd.restart   = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_pop = 1'b1;
          if (!stat.best_fin) begin
            state_nxt = S_IDLE;
          end else if (stat.others_left) begin
            state_nxt = S_CHECK;
          end else begin
            cmd.restart = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/kwm_dpath.sv =====
`timescale 1ns / 1ps
// merge datapath: per-list head slots, list status, minimum scan and the
// result register; depends on kwm_pkg and the assertion macro header
`include "k_way_sorted_merge_macros.svh"

module kwm_dpath #(
  parameter int MAX_LISTS  = kwm_pkg::DEF_MAX_LISTS,
  parameter int VALUE_BITS = kwm_pkg::DEF_VALUE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [kwm_pkg::CFG_W-1:0]         cfg_data,
  input  logic [kwm_pkg::IDX_W-1:0]         in_index,
  input  logic signed [kwm_pkg::ELEM_W-1:0] in_value,
  input  logic                              in_last,
  input  logic                              in_empty,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [kwm_pkg::ELEM_W-1:0] out_value,
  output logic [kwm_pkg::IDX_W-1:0]         out_src,
  output logic                              out_refill,
  output logic                              out_last,
  output logic                              out_none,
  input  kwm_pkg::kwm_cmd_t                 cmd,
  output kwm_pkg::kwm_stat_t                stat
);
  import kwm_pkg::*;

  // only lists reachable by the index field ever hold a head
  localparam int SLOTS = (MAX_LISTS < (1 << IDX_W)) ? MAX_LISTS : (1 << IDX_W);
  localparam int SIW   = $clog2(SLOTS);
  localparam int NW    = $clog2(MAX_LISTS + 1);

  localparam logic [1:0] ST_FIRST = 2'd0;
  localparam logic [1:0] ST_NEXT  = 2'd1;
  localparam logic [1:0] ST_IDLE  = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  logic [CFG_W-1:0]      cfg_r;
  logic [1:0]            status_r [SLOTS];
  logic [SLOTS-1:0]      fin_r;
  logic [SLOTS-1:0]      in_heap_r;
  logic                  merge_started_r;
  logic [VALUE_BITS-1:0] vals_r [SLOTS];

  logic [SIW-1:0]        scan_r;
  logic                  best_valid_r;
  logic [SIW-1:0]        best_idx_r;
  logic [VALUE_BITS-1:0] best_val_r;

  logic                  out_valid_r;
  logic [ELEM_W-1:0]     out_value_r;
  logic [IDX_W-1:0]      out_src_r;
  logic                  out_refill_r;
  logic                  out_last_r;
  logic                  out_none_r;

  logic [NW-1:0]         n_act;
  logic [SLOTS-1:0]      not_idle;
  logic                  waiting;
  logic                  in_hit;
  logic [SIW-1:0]        in_slot;
  logic [1:0]            in_st;
  logic                  push;
  logic                  mark_idle;
  logic                  cand;
  logic                  others_left;
  logic                  out_free;

  // register value 0 acts as one list, large values clamp to the maximum
  always_comb begin
    if (cfg_r == '0) begin
      n_act = NW'(1);
    end else if (int'(cfg_r) > MAX_LISTS) begin
      n_act = NW'(MAX_LISTS);
    end else begin
      n_act = NW'(cfg_r);
    end
  end

  always_comb begin
    waiting = (int'(n_act) > SLOTS);
    for (int i = 0; i < SLOTS; i++) begin
      not_idle[i] = (status_r[i] != ST_IDLE);
      if (i < int'(n_act) && not_idle[i]) begin
        waiting = 1'b1;
      end
    end
  end

  assign in_hit    = (int'(in_index) < int'(n_act));
  assign in_slot   = in_index[SIW-1:0];
  assign in_st     = status_r[in_slot];
  assign push      = in_hit && !in_empty && (in_st != ST_IDLE);
  // an empty marker only counts as a first element
  assign mark_idle = in_hit && ((in_st == ST_FIRST) || (in_st == ST_NEXT && !in_empty));

  // strict compare keeps the lowest list on equal values
  assign cand = in_heap_r[scan_r] &&
                (!best_valid_r || ($signed(vals_r[scan_r]) < $signed(best_val_r)));

  assign others_left = (in_heap_r & ~(SLOTS'(1) << best_idx_r)) != '0;
  assign out_free    = !out_valid_r || out_ready;

  always_comb begin
    stat               = '0;
    stat.waiting       = waiting;
    stat.heap_empty    = (in_heap_r == '0);
    stat.merge_started = merge_started_r;
    stat.scan_last     = (scan_r == SIW'(SLOTS - 1));
    stat.best_fin      = fin_r[best_idx_r];
    stat.others_left   = others_left;
    stat.out_free      = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r           <= CFG_RESET;
      fin_r           <= '0;
      in_heap_r       <= '0;
      merge_started_r <= 1'b0;
      scan_r          <= '0;
      best_valid_r    <= 1'b0;
      out_valid_r     <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        status_r[i] <= ST_FIRST;
      end
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_data;
      end
      if (cmd.take && push) begin
        in_heap_r[in_slot] <= 1'b1;
        fin_r[in_slot]     <= in_last;
      end
      if (cmd.take && mark_idle) begin
        status_r[in_slot] <= ST_IDLE;
      end
      if (cmd.scan_clr) begin
        scan_r       <= '0;
        best_valid_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        scan_r <= scan_r + SIW'(1);
        if (cand) begin
          best_valid_r <= 1'b1;
        end
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.emit_none || cmd.emit_pop) begin
        out_valid_r <= 1'b1;
      end
      if (cmd.emit_pop) begin
        in_heap_r[best_idx_r] <= 1'b0;
        merge_started_r       <= 1'b1;
        if (!fin_r[best_idx_r]) begin
          status_r[best_idx_r] <= ST_NEXT;
        end
      end
      if (cmd.restart) begin
        fin_r           <= '0;
        in_heap_r       <= '0;
        merge_started_r <= 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          status_r[i] <= ST_FIRST;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && push) begin
      vals_r[in_slot] <= VALUE_BITS'($unsigned(in_value));
    end
    if (cmd.scan_step && cand) begin
      best_idx_r <= scan_r;
      best_val_r <= vals_r[scan_r];
    end
    if (cmd.emit_none) begin
      out_value_r  <= '0;
      out_src_r    <= '0;
      out_refill_r <= 1'b0;
      out_last_r   <= 1'b1;
      out_none_r   <= 1'b1;
    end else if (cmd.emit_pop) begin
      out_value_r  <= ELEM_W'(best_val_r);
      out_src_r    <= IDX_W'(best_idx_r);
      out_refill_r <= !fin_r[best_idx_r];
      out_last_r   <= fin_r[best_idx_r] && !others_left;
      out_none_r   <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_src    = out_src_r;
  assign out_refill = out_refill_r;
  assign out_last   = out_last_r;
  assign out_none   = out_none_r;

  `KWM_ASSERT_IMP(a_pop_has_best, clk, rst_n, cmd.emit_pop, best_valid_r)
  `KWM_ASSERT_IMP(a_emit_when_free, clk, rst_n, cmd.emit_pop || cmd.emit_none, out_free)
  `KWM_ASSERT_IMP(a_heap_heads_idle, clk, rst_n, 1'b1, (in_heap_r & not_idle) == '0)
  `KWM_ASSERT_NXT(a_restart_clears, clk, rst_n, cmd.restart,
                  (in_heap_r == '0) && !merge_started_r)

endmodule

// ===== rtl/core/k_way_sorted_merge.sv =====
`timescale 1ns / 1ps
// k-way merge of ascending lists: top level joining sequencer and datapath
// depends on kwm_pkg, kwm_if, kwm_ctrl and kwm_dpath
//
// usage:
//   in_chan carries list elements (list_index, elem_value, last_in_list,
//   list_empty); a merge starts with one first element or empty marker from
//   each list 0..lists_in_use-1, then each refill_needed result asks for the
//   next element of source_list. requests for lists not being waited on are
//   taken and dropped.
//   out_chan returns merged values smallest first, lowest list on ties;
//   merge_last flags the end, no_elements the all-empty case.
//   cfg_we/cfg_data write lists_in_use (reset 8) between requests.
// sequence:
//   a request that only fills a head returns to idle after the check state.
//   one that triggers a pop runs the check state, the minimum scan and the
//   emit state before its result is valid; a pop from a finished list with
//   other heads left runs the check and the scan again. the minimum scan
//   reads one head slot a cycle. in_chan is ready only between requests.
// reset: all lists await a first element, heap empty, no result pending.
// stalls: the result register holds while out_chan.ready is low; a new
//   request is still taken, and a pop waits until the register frees up.
module k_way_sorted_merge #(
  parameter int MAX_LISTS  = kwm_pkg::DEF_MAX_LISTS,
  parameter int VALUE_BITS = kwm_pkg::DEF_VALUE_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [kwm_pkg::CFG_W-1:0] cfg_data,
  kwm_in_if.sink                    in_chan,
  kwm_out_if.source                 out_chan
);
  import kwm_pkg::*;

  kwm_cmd_t  cmd;
  kwm_stat_t stat;
  logic      in_ready;

  kwm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kwm_dpath #(
    .MAX_LISTS  (MAX_LISTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_index   (in_chan.list_index),
    .in_value   (in_chan.elem_value),
    .in_last    (in_chan.last_in_list),
    .in_empty   (in_chan.list_empty),
    .out_ready  (out_chan.ready),
    .out_valid  (out_chan.valid),
    .out_value  (out_chan.out_value),
    .out_src    (out_chan.source_list),
    .out_refill (out_chan.refill_needed),
    .out_last   (out_chan.merge_last),
    .out_none   (out_chan.no_elements),
    .cmd        (cmd),
    .stat       (stat)
  );

  assign in_chan.ready = in_ready;

endmodule
